// File: rtl/core/ese_pkg.sv
// shared types, constants and register codes for the encoder speed estimator
`timescale 1ns / 1ps
package ese_pkg;

    // default angle resolution in bits per turn
    localparam int ANGLE_BITS_DEF = 14;

    // configuration register widths and port shape
    localparam int GAIN_W     = 24;
    localparam int ALPHA_W    = 17;
    localparam int THR_W      = 31;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 2'd2;

    // register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd251327;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd6554;
    localparam logic [THR_W-1:0]   THR_RST   = 31'd26214400;

    // result widths
    localparam int SPEED_W = 32;
    localparam int TURN_W  = 48;

    // shared multiplier shape: signed a x signed b
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // raw speed is split here for the alpha multiply
    localparam int RAW_SPLIT = 24;

    // fixed-point constants
    localparam logic [ALPHA_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [ALPHA_W-1:0] FAST_ALPHA = 17'd19661;
    localparam logic [19:0]        RPM_K_Q16  = 20'd625823;
    localparam int                 FILT_SHIFT = 16;
    localparam int                 RPM_SHIFT  = 24;
    localparam int                 FILT_ROUND = 32768;
    localparam int                 RPM_ROUND  = 8388608;

    localparam logic signed [SPEED_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SPEED_W-1:0] S32_MIN = 32'sh8000_0000;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_RAW,
        S_JUMP,
        S_LO,
        S_HI,
        S_OLD,
        S_SUM,
        S_FILT,
        S_RPM,
        S_RPMW,
        S_OUT
    } t_state;

    // operand pair chosen for the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RAW,
        MUL_LO,
        MUL_HI,
        MUL_OLD,
        MUL_RPM
    } t_mul_op;

    // datapath strobes from the sequencer
    typedef struct packed {
        logic    in_ready;
        logic    ld_delta;
        logic    ld_accum;
        logic    ld_jump;
        logic    acc_lo;
        logic    acc_hi;
        logic    acc_old;
        logic    ld_filt;
        logic    ld_rpm;
        logic    ld_out;
        t_mul_op mul_op;
    } t_ctrl;

endpackage

// File: rtl/core/ese_mul.sv
// shared multiplier with operand selection and a registered product
`timescale 1ns / 1ps
module ese_mul
    import ese_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  t_mul_op                           i_op,
    input  logic signed [ANGLE_BITS:0]        i_delta,
    input  logic        [GAIN_W-1:0]          i_gain,
    input  logic signed [ANGLE_BITS+GAIN_W:0] i_raw,
    input  logic        [ALPHA_W-1:0]         i_alpha,
    input  logic signed [SPEED_W-1:0]         i_filt,
    output logic signed [PROD_W-1:0]          o_prod
);

    localparam int RAW_W = ANGLE_BITS + GAIN_W + 1;
    localparam int HI_W  = RAW_W - RAW_SPLIT;

    logic signed [HI_W-1:0]    w_raw_hi;
    logic        [ALPHA_W-1:0] w_one_minus;
    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  n_prod;

    assign w_raw_hi    = i_raw[RAW_W-1:RAW_SPLIT];
    assign w_one_minus = ONE_Q16 - i_alpha;

    // operand select
    always_comb begin
        unique case (i_op)
            MUL_RAW: begin
                w_a = MUL_A_W'(i_delta);
                w_b = $signed(MUL_B_W'(i_gain));
            end
            MUL_LO: begin
                w_a = $signed(MUL_A_W'(i_raw[RAW_SPLIT-1:0]));
                w_b = $signed(MUL_B_W'(i_alpha));
            end
            MUL_HI: begin
                w_a = MUL_A_W'(w_raw_hi);
                w_b = $signed(MUL_B_W'(i_alpha));
            end
            MUL_OLD: begin
                w_a = MUL_A_W'(i_filt);
                w_b = $signed(MUL_B_W'(w_one_minus));
            end
            MUL_RPM: begin
                w_a = MUL_A_W'(i_filt);
                w_b = $signed(MUL_B_W'(RPM_K_Q16));
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // one multiply per cycle, product registered
    assign n_prod = w_a * w_b;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/ese_seq.sv
// sequencer stepping one sample through the shared multiplier
`timescale 1ns / 1ps
module ese_seq
    import ese_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_primed,
    input  logic   i_out_free,
    output t_state o_state,
    output t_ctrl  o_ctrl
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DELTA;
            end
            S_DELTA: n_state = i_primed ? S_RAW : S_OUT;
            S_RAW:   n_state = S_JUMP;
            S_JUMP:  n_state = S_LO;
            S_LO:    n_state = S_HI;
            S_HI:    n_state = S_OLD;
            S_OLD:   n_state = S_SUM;
            S_SUM:   n_state = S_FILT;
            S_FILT:  n_state = S_RPM;
            S_RPM:   n_state = S_RPMW;
            S_RPMW:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath strobes
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.mul_op   = MUL_NONE;
        unique case (r_state)
            S_IDLE:  o_ctrl.in_ready = 1'b1;
            S_DELTA: o_ctrl.ld_delta = 1'b1;
            S_RAW: begin
                o_ctrl.ld_accum = 1'b1;
                o_ctrl.mul_op   = MUL_RAW;
            end
            S_JUMP:  o_ctrl.ld_jump = 1'b1;
            S_LO:    o_ctrl.mul_op  = MUL_LO;
            S_HI: begin
                o_ctrl.acc_lo = 1'b1;
                o_ctrl.mul_op = MUL_HI;
            end
            S_OLD: begin
                o_ctrl.acc_hi = 1'b1;
                o_ctrl.mul_op = MUL_OLD;
            end
            S_SUM:   o_ctrl.acc_old = 1'b1;
            S_FILT:  o_ctrl.ld_filt = 1'b1;
            S_RPM:   o_ctrl.mul_op  = MUL_RPM;
            S_RPMW:  o_ctrl.ld_rpm  = 1'b1;
            S_OUT:   o_ctrl.ld_out  = i_out_free;
            default: o_ctrl.in_ready = 1'b0;
        endcase
    end

    assign o_state = r_state;

endmodule

// File: rtl/core/encoder_speed_estimator_top.sv
// top level of the encoder speed estimator: registers, datapath and output stage
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ----------------------------------------
// input     in         i_in_valid / o_in_stall   i_angle
// result    out        o_out_valid / i_out_stall o_speed_rad o_mech_rpm o_turn_count
//                                                o_first_sample
// config    in         i_cfg_we                  i_cfg_index i_cfg_data
//
// a sample passes through every sequencer state before the next acceptance, the priming sample
// only idle, delta and output; five products pass one at a time through the shared multiplier
// reset (synchronous, active low) clears the sequencer, the estimator state and the registers
// results wait in the output register; the sequencer holds in its last state while that
// register is occupied and stalled, and no new sample is taken until the result is loaded
`timescale 1ns / 1ps
module encoder_speed_estimator_top
    import ese_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ANGLE_BITS-1:0]      i_angle,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SPEED_W-1:0]  o_speed_rad,
    output logic signed [SPEED_W-1:0]  o_mech_rpm,
    output logic signed [TURN_W-1:0]   o_turn_count,
    output logic                       o_first_sample,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int D_W    = ANGLE_BITS + 1;
    localparam int RAW_W  = D_W + GAIN_W;
    localparam int DIFF_W = RAW_W + 1;
    localparam int ACC_W  = RAW_W + 18;
    localparam int SH_W   = ACC_W - FILT_SHIFT;
    localparam int RPM_W  = PROD_W - RPM_SHIFT;

    localparam logic signed [D_W-1:0]    HALF_TURN = D_W'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [D_W-1:0]    FULL_TURN = D_W'(1) <<< ANGLE_BITS;
    localparam logic signed [ACC_W-1:0]  ACC_ROUND = ACC_W'(FILT_ROUND);
    localparam logic signed [PROD_W-1:0] RPM_RND   = PROD_W'(RPM_ROUND);

    // configuration registers
    logic [GAIN_W-1:0]  r_gain;
    logic [ALPHA_W-1:0] r_alpha_cfg;
    logic [THR_W-1:0]   r_thr;

    // estimator state and working registers
    logic [ANGLE_BITS-1:0]     r_cur;
    logic [ANGLE_BITS-1:0]     r_prev;
    logic                      r_primed;
    logic signed [D_W-1:0]     r_delta;
    logic signed [TURN_W-1:0]  r_accum;
    logic signed [RAW_W-1:0]   r_raw;
    logic [ALPHA_W-1:0]        r_alpha;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SPEED_W-1:0] r_filt;
    logic signed [SPEED_W-1:0] r_rpm;
    logic                      r_first;

    // output register
    logic                      r_out_valid;
    logic signed [SPEED_W-1:0] r_out_rad;
    logic signed [SPEED_W-1:0] r_out_rpm;
    logic signed [TURN_W-1:0]  r_out_turn;
    logic                      r_out_first;

    logic signed [D_W-1:0]     w_dang;
    logic signed [D_W-1:0]     n_delta;
    logic signed [RAW_W-1:0]   w_raw;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [DIFF_W-1:0]  w_thr;
    logic                      w_in_band;
    logic [ALPHA_W-1:0]        w_alpha_pick;
    logic [ALPHA_W-1:0]        n_alpha;
    logic signed [ACC_W-1:0]   w_prod_acc;
    logic signed [SH_W-1:0]    w_filt_shr;
    logic signed [SPEED_W-1:0] n_filt;
    logic signed [PROD_W-1:0]  w_rpm_sum;
    logic signed [RPM_W-1:0]   w_rpm_shr;
    logic signed [SPEED_W-1:0] n_rpm;
    logic signed [PROD_W-1:0]  w_prod;
    logic                      w_out_free;
    t_state                    w_state;
    t_ctrl                     w_ctrl;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // sequencer
    ese_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_primed   (r_primed),
        .i_out_free (w_out_free),
        .o_state    (w_state),
        .o_ctrl     (w_ctrl)
    );

    // shared multiplier
    ese_mul #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_op    (w_ctrl.mul_op),
        .i_delta (r_delta),
        .i_gain  (r_gain),
        .i_raw   (r_raw),
        .i_alpha (r_alpha),
        .i_filt  (r_filt),
        .o_prod  (w_prod)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RST;
            r_alpha_cfg <= ALPHA_RST;
            r_thr       <= THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPEED_GAIN:     r_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_FILTER_ALPHA:   r_alpha_cfg <= i_cfg_data[ALPHA_W-1:0];
                CFG_JUMP_THRESHOLD: r_thr       <= i_cfg_data[THR_W-1:0];
                default:            r_thr       <= r_thr;
            endcase
        end
    end

    // angle delta unwrapped by half a turn
    assign w_dang = $signed(D_W'(r_cur)) - $signed(D_W'(r_prev));

    always_comb begin
        if (w_dang > HALF_TURN) begin
            n_delta = w_dang - FULL_TURN;
        end else if (w_dang < -HALF_TURN) begin
            n_delta = w_dang + FULL_TURN;
        end else begin
            n_delta = w_dang;
        end
    end

    // jump test on the raw speed and filter weight pick
    assign w_raw     = RAW_W'(w_prod);
    assign w_diff    = DIFF_W'(w_raw) - DIFF_W'(r_filt);
    assign w_thr     = $signed(DIFF_W'(r_thr));
    assign w_in_band = (w_diff < w_thr) && (w_diff > -w_thr);

    assign w_alpha_pick = w_in_band ? r_alpha_cfg : FAST_ALPHA;
    assign n_alpha      = (w_alpha_pick > ONE_Q16) ? ONE_Q16 : w_alpha_pick;

    // filter sum: floor shift by 16 and saturate
    assign w_prod_acc = ACC_W'(w_prod);
    assign w_filt_shr = SH_W'(r_acc >>> FILT_SHIFT);

    always_comb begin
        if (w_filt_shr > SH_W'(S32_MAX)) begin
            n_filt = S32_MAX;
        end else if (w_filt_shr < SH_W'(S32_MIN)) begin
            n_filt = S32_MIN;
        end else begin
            n_filt = SPEED_W'(w_filt_shr);
        end
    end

    // rpm: round, floor shift by 24 and saturate
    assign w_rpm_sum = w_prod + RPM_RND;
    assign w_rpm_shr = RPM_W'(w_rpm_sum >>> RPM_SHIFT);

    always_comb begin
        if (w_rpm_shr > RPM_W'(S32_MAX)) begin
            n_rpm = S32_MAX;
        end else if (w_rpm_shr < RPM_W'(S32_MIN)) begin
            n_rpm = S32_MIN;
        end else begin
            n_rpm = SPEED_W'(w_rpm_shr);
        end
    end

    // estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_primed <= 1'b0;
            r_filt   <= '0;
            r_accum  <= '0;
        end else begin
            if (w_ctrl.ld_delta) begin
                r_prev   <= r_cur;
                r_primed <= 1'b1;
                if (!r_primed) begin
                    r_filt <= '0;
                end
            end
            if (w_ctrl.ld_accum) begin
                r_accum <= r_accum + TURN_W'(r_delta);
            end
            if (w_ctrl.ld_filt) begin
                r_filt <= n_filt;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_ctrl.in_ready && i_in_valid) begin
            r_cur <= i_angle;
        end
        if (w_ctrl.ld_delta) begin
            r_delta <= n_delta;
            r_first <= !r_primed;
            if (!r_primed) begin
                r_rpm <= '0;
            end
        end
        if (w_ctrl.ld_jump) begin
            r_raw   <= w_raw;
            r_alpha <= n_alpha;
        end
        if (w_ctrl.acc_lo) begin
            r_acc <= w_prod_acc + ACC_ROUND;
        end else if (w_ctrl.acc_hi) begin
            r_acc <= r_acc + (w_prod_acc <<< RAW_SPLIT);
        end else if (w_ctrl.acc_old) begin
            r_acc <= r_acc + w_prod_acc;
        end
        if (w_ctrl.ld_rpm) begin
            r_rpm <= n_rpm;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.ld_out) begin
            r_out_rad   <= r_filt;
            r_out_rpm   <= r_rpm;
            r_out_turn  <= r_accum;
            r_out_first <= r_first;
        end
    end

    assign o_in_stall     = !w_ctrl.in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_speed_rad    = r_out_rad;
    assign o_mech_rpm     = r_out_rpm;
    assign o_turn_count   = r_out_turn;
    assign o_first_sample = r_out_first;

    // an accepted sample always starts with the delta step
    a_accept_to_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (w_state == S_DELTA))
        else $error("accepted sample did not enter the delta step");

    // a priming result reports zero speed
    a_prime_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_first) |-> (r_out_rad == '0 && r_out_rpm == '0))
        else $error("priming result carries nonzero speed");

    // once primed the estimator stays primed until reset
    a_primed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed)
        else $error("primed flag dropped without reset");

    // filter weight never exceeds one
    a_alpha_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_ctrl.ld_jump) |-> (r_alpha <= ONE_Q16))
        else $error("filter weight above one");

    // loading a result frees the sequencer and shows the result
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ld_out |=> (r_out_valid && w_state == S_IDLE))
        else $error("result load did not complete the transaction");

endmodule

// File: tb/encoder_speed_estimator_top_tb.sv
// self-checking testbench for the encoder speed estimator with its own speed predictor
`timescale 1ns / 1ps
module encoder_speed_estimator_top_tb;
    import ese_pkg::*;

    localparam int     ANGLE_W      = ANGLE_BITS_DEF;
    localparam longint COUNTS_TURN  = longint'(1) << ANGLE_W;
    localparam longint HALF_TURN    = COUNTS_TURN / 2;
    localparam longint ONE_WEIGHT   = 65536;
    localparam longint FAST_WEIGHT  = 19661;
    localparam longint RPM_SCALE    = 625823;
    localparam longint FILT_HALF    = 32768;
    localparam longint RPM_HALF     = 8388608;
    localparam longint S32_TOP      = 2147483647;
    localparam longint S32_BOT      = -S32_TOP - 1;
    localparam int     GAIN_TOP     = 16777215;
    localparam int     THR_TOP      = 2147483647;
    localparam int     RUN_LIMIT    = 400000;
    localparam int     HOLD_CYCLES  = 300;

    // one predicted result transaction
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_rad;
        logic signed [SPEED_W-1:0] mech_rpm;
        logic signed [TURN_W-1:0]  turn_count;
        logic                      first_sample;
    } t_estimate;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [ANGLE_W-1:0]        i_angle = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [SPEED_W-1:0] o_speed_rad;
    logic signed [SPEED_W-1:0] o_mech_rpm;
    logic signed [TURN_W-1:0]  o_turn_count;
    logic                      o_first_sample;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    // predictor copy of the registers and estimator state
    logic [GAIN_W-1:0]         reg_gain = GAIN_RST;
    logic [ALPHA_W-1:0]        reg_alpha = ALPHA_RST;
    logic [THR_W-1:0]          reg_thresh = THR_RST;
    logic [ANGLE_W-1:0]        est_prev_angle = '0;
    logic                      est_primed = 1'b0;
    logic signed [SPEED_W-1:0] est_filtered = '0;
    logic [TURN_W-1:0]         est_turns = '0;

    t_estimate          pending_estimates[$];
    t_estimate          head_est;
    int                 fail_count = 0;
    int                 cycle_count = 0;
    bit                 quiet = 1'b0;
    int                 hold_request = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    logic [ANGLE_W-1:0] rotor_angle = '0;

    encoder_speed_estimator_top #(
        .ANGLE_BITS(ANGLE_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_angle        (i_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_speed_rad    (o_speed_rad),
        .o_mech_rpm     (o_mech_rpm),
        .o_turn_count   (o_turn_count),
        .o_first_sample (o_first_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall: random, quiet stretches and one long hold-off
    always @(posedge i_clk) begin
        if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 23);
        end
    end

    // compare each result transaction against the oldest estimate
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_estimates.size() == 0) begin
                $display("%0t: result with no estimate pending", $time);
                fail_count++;
            end else begin
                head_est = pending_estimates.pop_front();
                if (o_speed_rad !== head_est.speed_rad) begin
                    $display("%0t: speed_rad expected %0d actual %0d",
                             $time, head_est.speed_rad, o_speed_rad);
                    fail_count++;
                end
                if (o_mech_rpm !== head_est.mech_rpm) begin
                    $display("%0t: mech_rpm expected %0d actual %0d",
                             $time, head_est.mech_rpm, o_mech_rpm);
                    fail_count++;
                end
                if (o_turn_count !== head_est.turn_count) begin
                    $display("%0t: turn_count expected %0d actual %0d",
                             $time, head_est.turn_count, o_turn_count);
                    fail_count++;
                end
                if (o_first_sample !== head_est.first_sample) begin
                    $display("%0t: first_sample expected %0d actual %0d",
                             $time, head_est.first_sample, o_first_sample);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [SPEED_W-1:0] clamp_s32(input longint v);
        if (v > S32_TOP) begin
            return S32_TOP[SPEED_W-1:0];
        end
        if (v < S32_BOT) begin
            return S32_BOT[SPEED_W-1:0];
        end
        return v[SPEED_W-1:0];
    endfunction

    // speed estimate for one accepted angle sample, advancing the state copy
    function automatic t_estimate predict_estimate(input logic [ANGLE_W-1:0] ang);
        t_estimate e;
        longint    cur;
        longint    prv;
        longint    d;
        longint    gain;
        longint    thr;
        longint    w;
        longint    filt_old;
        longint    raw;
        longint    diff;
        longint    acc;
        longint    rpm;
        cur = longint'(ang);
        prv = longint'(est_prev_angle);
        // priming sample only stores the angle, clears the filtered speed and reports zero speed
        if (!est_primed) begin
            est_prev_angle = ang;
            est_primed = 1'b1;
            est_filtered = '0;
            e.speed_rad = '0;
            e.mech_rpm = '0;
            e.turn_count = est_turns;
            e.first_sample = 1'b1;
            return e;
        end
        // unwrap by half a turn
        d = cur - prv;
        if (d > HALF_TURN) begin
            d -= COUNTS_TURN;
        end else if (d < -HALF_TURN) begin
            d += COUNTS_TURN;
        end
        est_turns = est_turns + d[TURN_W-1:0];
        gain = longint'(reg_gain);
        thr = longint'(reg_thresh);
        filt_old = longint'(est_filtered);
        raw = d * gain;
        diff = raw - filt_old;
        if (diff < 0) begin
            diff = -diff;
        end
        // normal weight below the jump threshold, fast weight at or above it, never above one
        w = (diff < thr) ? longint'(reg_alpha) : FAST_WEIGHT;
        if (w > ONE_WEIGHT) begin
            w = ONE_WEIGHT;
        end
        acc = w * raw + (ONE_WEIGHT - w) * filt_old + FILT_HALF;
        est_filtered = clamp_s32(acc >>> 16);
        rpm = longint'(est_filtered) * RPM_SCALE + RPM_HALF;
        est_prev_angle = ang;
        e.speed_rad = est_filtered;
        e.mech_rpm = clamp_s32(rpm >>> 24);
        e.turn_count = est_turns;
        e.first_sample = 1'b0;
        return e;
    endfunction

    // offer one sample and hold it until accepted
    task automatic send_sample(input logic [ANGLE_W-1:0] ang);
        while (!quiet && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_angle <= ang;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_estimates.push_back(predict_estimate(ang));
        rotor_angle = ang;
    endtask

    // stop offering and let every outstanding result drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_estimates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SPEED_GAIN:     reg_gain = data[GAIN_W-1:0];
            CFG_FILTER_ALPHA:   reg_alpha = data[ALPHA_W-1:0];
            CFG_JUMP_THRESHOLD: reg_thresh = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] gain,
                                  input logic [CFG_DATA_W-1:0] alpha,
                                  input logic [CFG_DATA_W-1:0] thr);
        wait_idle();
        write_register(CFG_SPEED_GAIN, gain);
        write_register(CFG_FILTER_ALPHA, alpha);
        write_register(CFG_JUMP_THRESHOLD, thr);
        i_cfg_we <= 1'b0;
    endtask

    // rotation at a random speed mixed with jumps, half turns and stops
    task automatic send_motion(input int count, input int max_step);
        int step;
        int delta;
        int pick;
        step = int'($urandom_range(0, 2 * max_step)) - max_step;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            delta = 0;
            if (pick < 65) begin
                delta = step + int'($urandom_range(0, 6)) - 3;
            end else if (pick < 78) begin
                delta = int'($urandom_range(0, int'(COUNTS_TURN) - 1));
            end else if (pick < 86) begin
                case ($urandom_range(3))
                    0: delta = int'(HALF_TURN);
                    1: delta = -int'(HALF_TURN);
                    2: delta = int'(HALF_TURN) + 1;
                    default: delta = -int'(HALF_TURN) - 1;
                endcase
            end else if (pick >= 92) begin
                delta = int'($urandom_range(0, 40)) - 20;
            end
            send_sample(rotor_angle + delta[ANGLE_W-1:0]);
        end
    endtask

    // priming sample, then half-turn unwrap edges and angle wrap at the default settings
    task automatic test_priming_and_unwrap();
        send_sample(14'd100);
        send_sample(14'd8292);
        send_sample(14'd100);
        send_sample(14'd8293);
        send_sample(14'd100);
        send_sample(14'd0);
        send_sample(14'd16383);
        send_sample(14'd0);
        send_sample(14'd0);
    endtask

    // register extremes: saturation both ways, weight above one, zero weight and threshold
    task automatic test_register_extremes();
        apply_settings(CFG_DATA_W'(GAIN_TOP), CFG_DATA_W'(ONE_Q16), CFG_DATA_W'(THR_TOP));
        send_sample(14'd8192);
        send_sample(14'd0);
        apply_settings(31'd1000, 31'd131071, CFG_DATA_W'(THR_TOP));
        send_sample(14'd10);
        send_sample(14'd30);
        apply_settings(31'd5000, 31'd0, CFG_DATA_W'(THR_TOP));
        send_sample(14'd50);
        send_sample(14'd16000);
        apply_settings(31'd0, 31'd30000, 31'd0);
        send_sample(14'd16100);
        send_sample(14'd16383);
    endtask

    // several random register settings, each with its own motion profile
    task automatic test_random_settings();
        logic [CFG_DATA_W-1:0] gain;
        logic [CFG_DATA_W-1:0] alpha;
        logic [CFG_DATA_W-1:0] thr;
        int                    max_step;
        for (int p = 0; p < 7; p++) begin
            case ($urandom_range(4))
                0: gain = '0;
                1: gain = CFG_DATA_W'(GAIN_TOP);
                2: gain = CFG_DATA_W'($urandom_range(1, 4095));
                3: gain = CFG_DATA_W'($urandom_range(100000, 400000));
                default: gain = CFG_DATA_W'($urandom());
            endcase
            case ($urandom_range(4))
                0: alpha = '0;
                1: alpha = CFG_DATA_W'(ONE_Q16);
                2: alpha = CFG_DATA_W'($urandom_range(65537, 131071));
                3: alpha = CFG_DATA_W'($urandom_range(1, 65535));
                default: alpha = CFG_DATA_W'($urandom());
            endcase
            case ($urandom_range(4))
                0: thr = '0;
                1: thr = CFG_DATA_W'(THR_TOP);
                2: thr = CFG_DATA_W'($urandom_range(1, 1 << 20));
                3: thr = CFG_DATA_W'($urandom_range(1 << 20, 1 << 28));
                default: thr = CFG_DATA_W'($urandom());
            endcase
            case ($urandom_range(3))
                0: max_step = 5;
                1: max_step = 200;
                2: max_step = 4000;
                default: max_step = 8192;
            endcase
            apply_settings(gain, alpha, thr);
            send_motion(100 + $urandom_range(0, 30), max_step);
        end
    endtask

    // back-to-back transactions with no idling on either side
    task automatic test_steady_rotation();
        apply_settings(CFG_DATA_W'(GAIN_RST), CFG_DATA_W'(ALPHA_RST), CFG_DATA_W'(THR_RST));
        quiet = 1'b1;
        send_motion(150, 300);
        quiet = 1'b0;
    endtask

    // receiver holds off while samples keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_request++;
        send_motion(60, 1000);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_priming_and_unwrap();
        test_register_extremes();
        test_random_settings();
        test_steady_rotation();
        test_output_backpressure();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
